>>> rtl/trilin_pkg.sv
package trilin_pkg;

   // Sample and weight formats (signed 16.0 integer samples, unsigned 0.16 fixed point weights)
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 16;

   // Product of a 17-bit corner difference and a 17-bit non-negative weight
   localparam int PROD_WIDTH = DATA_WIDTH + FRAC_BITS + 1;

   // Two register stages per axis, three axes
   localparam int LERP_STAGES = 2;
   localparam int STAGE_COUNT = 3 * LERP_STAGES;

   // Lanes on the first axis, then on the second
   localparam int X_LANES = 4;
   localparam int Y_LANES = 2;

   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic        [FRAC_BITS-1:0]  weight_type;

   // Load enables for the two register stages of one interpolation lane
   typedef struct packed {
      logic mult;
      logic sum;
   } lerp_en_type;

endpackage

>>> rtl/trilin_if.sv
interface trilin_req_if;
   import trilin_pkg::*;

   logic       valid;
   logic       ready;
   sample_type corner_x0y0z0;
   sample_type corner_x1y0z0;
   sample_type corner_x0y1z0;
   sample_type corner_x1y1z0;
   sample_type corner_x0y0z1;
   sample_type corner_x1y0z1;
   sample_type corner_x0y1z1;
   sample_type corner_x1y1z1;
   weight_type weight_x;
   weight_type weight_y;
   weight_type weight_z;

   modport source (
      output valid,
      input  ready,
      output corner_x0y0z0, corner_x1y0z0, corner_x0y1z0, corner_x1y1z0,
      output corner_x0y0z1, corner_x1y0z1, corner_x0y1z1, corner_x1y1z1,
      output weight_x, weight_y, weight_z
   );

   modport sink (
      input  valid,
      output ready,
      input  corner_x0y0z0, corner_x1y0z0, corner_x0y1z0, corner_x1y1z0,
      input  corner_x0y0z1, corner_x1y0z1, corner_x0y1z1, corner_x1y1z1,
      input  weight_x, weight_y, weight_z
   );
endinterface

interface trilin_rsp_if;
   import trilin_pkg::*;

   logic       valid;
   logic       ready;
   sample_type interpolated;

   modport source (
      output valid,
      input  ready,
      output interpolated
   );

   modport sink (
      input  valid,
      output ready,
      input  interpolated
   );
endinterface

>>> rtl/trilinear_interp_fixed16.sv
// Trilinear interpolation of one voxel cell, signed 16-bit samples, 16-bit weights.
//
// req_chan carries the eight cell corners and the x, y and z weights; rsp_chan
// returns one interpolated signed 16-bit value per item, in order. Both are
// valid/ready channels; an item moves when valid and ready are high at a
// rising clock edge.
//
// Six register stages: each axis is one multiply register and one add/shift
// register. rsp_chan.valid rises when an item reaches the last stage, where its
// result waits to leave. Four lanes work the x axis in parallel, two the y axis,
// and one final lane merges along z. Throughput is one item per cycle while
// rsp_chan is not stalled, set by the single multiplier in each lane.
//
// Reset (synchronous, active high) empties the pipeline; rsp_chan.valid is low
// after it. When the receiver stalls, the result holds on rsp_chan and empty
// stages ahead of it keep filling, so up to six items are taken before
// req_chan.ready drops. Ready depends on rsp_chan.ready in the same cycle.
module trilinear_interp_fixed16 (
   input  logic         clock,
   input  logic         reset,
   trilin_req_if.sink   req_chan,
   trilin_rsp_if.source rsp_chan
);
   import trilin_pkg::*;

   logic [STAGE_COUNT-1:0] valid_ff;
   logic [STAGE_COUNT-1:0] valid_in;
   logic [STAGE_COUNT-1:0] load_en;

   weight_type wy_ff [LERP_STAGES];
   weight_type wz_ff [2*LERP_STAGES];

   sample_type lo_x [X_LANES];
   sample_type hi_x [X_LANES];
   sample_type res_x [X_LANES];
   sample_type res_y [Y_LANES];
   sample_type res_z;

   lerp_en_type en_x;
   lerp_en_type en_y;
   lerp_en_type en_z;

   // A stage loads when it is empty or its contents move on
   always_comb begin
      load_en[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || rsp_chan.ready;
      for (int i = STAGE_COUNT - 2; i >= 0; i--) begin
         load_en[i] = !valid_ff[i] || load_en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = req_chan.valid;
      for (int i = 1; i < STAGE_COUNT; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            if (load_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // Weight delay lines, matched to the stage where each axis starts
   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         wy_ff[0] <= req_chan.weight_y;
         wz_ff[0] <= req_chan.weight_z;
      end
      for (int i = 1; i < LERP_STAGES; i++) begin
         if (load_en[i]) begin
            wy_ff[i] <= wy_ff[i-1];
         end
      end
      for (int i = 1; i < 2 * LERP_STAGES; i++) begin
         if (load_en[i]) begin
            wz_ff[i] <= wz_ff[i-1];
         end
      end
   end

   assign en_x = '{mult: load_en[0], sum: load_en[1]};
   assign en_y = '{mult: load_en[2], sum: load_en[3]};
   assign en_z = '{mult: load_en[4], sum: load_en[5]};

   // x axis lanes: pairs along x for each (y, z)
   assign lo_x[0] = req_chan.corner_x0y0z0;
   assign hi_x[0] = req_chan.corner_x1y0z0;
   assign lo_x[1] = req_chan.corner_x0y1z0;
   assign hi_x[1] = req_chan.corner_x1y1z0;
   assign lo_x[2] = req_chan.corner_x0y0z1;
   assign hi_x[2] = req_chan.corner_x1y0z1;
   assign lo_x[3] = req_chan.corner_x0y1z1;
   assign hi_x[3] = req_chan.corner_x1y1z1;

   for (genvar g = 0; g < X_LANES; g++) begin : g_x_lane
      trilin_lerp u_lerp (
         .clock  (clock),
         .en     (en_x),
         .lo     (lo_x[g]),
         .hi     (hi_x[g]),
         .weight (req_chan.weight_x),
         .result (res_x[g])
      );
   end

   // y axis lanes: lane 0 at low z, lane 1 at high z
   for (genvar g = 0; g < Y_LANES; g++) begin : g_y_lane
      trilin_lerp u_lerp (
         .clock  (clock),
         .en     (en_y),
         .lo     (res_x[2*g]),
         .hi     (res_x[2*g+1]),
         .weight (wy_ff[LERP_STAGES-1]),
         .result (res_y[g])
      );
   end

   // Merge along z
   trilin_lerp u_lerp_z (
      .clock  (clock),
      .en     (en_z),
      .lo     (res_y[0]),
      .hi     (res_y[1]),
      .weight (wz_ff[2*LERP_STAGES-1]),
      .result (res_z)
   );

   assign req_chan.ready        = load_en[0];
   assign rsp_chan.valid        = valid_ff[STAGE_COUNT-1];
   assign rsp_chan.interpolated = res_z;

endmodule

>>> rtl/trilin_lerp.sv
module trilin_lerp (
   input  logic                    clock,
   input  trilin_pkg::lerp_en_type en,
   input  trilin_pkg::sample_type  lo,
   input  trilin_pkg::sample_type  hi,
   input  trilin_pkg::weight_type  weight,
   output trilin_pkg::sample_type  result
);
   import trilin_pkg::*;

   // lo*(1-w) + hi*w is computed as lo*2^16 + (hi-lo)*w
   logic signed [DATA_WIDTH:0]   diff;
   logic signed [PROD_WIDTH:0]   prod_full;
   logic signed [PROD_WIDTH-1:0] prod_in;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   sample_type                   lo_ff;
   logic signed [PROD_WIDTH-1:0] sum;
   sample_type                   result_in;
   sample_type                   result_ff;

   // Multiply stage
   always_comb begin
      diff      = {hi[DATA_WIDTH-1], hi} - {lo[DATA_WIDTH-1], lo};
      prod_full = diff * $signed({1'b0, weight});
      prod_in   = prod_full[PROD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.mult) begin
         prod_ff <= prod_in;
         lo_ff   <= lo;
      end
   end

   // Add the scaled low sample, then arithmetic shift by the fraction width
   always_comb begin
      sum       = {lo_ff[DATA_WIDTH-1], lo_ff, {FRAC_BITS{1'b0}}} + prod_ff;
      result_in = sum[FRAC_BITS+DATA_WIDTH-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (en.sum) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/trilin_checker.sv
module trilin_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input trilin_pkg::sample_type interpolated
);
   import trilin_pkg::*;

   // A stalled result stays presented and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(interpolated))
      else $error("result changed while stalled");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A receiver that takes results never blocks the input
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input blocked while output drains");

   // With no result waiting, the pipeline has room
   a_room: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output stage");

   // An item taken while the receiver stays ready passes through every stage and shows up as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("item did not arrive after pipeline latency");

endmodule

bind trilinear_interp_fixed16 trilin_checker u_trilin_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .interpolated (rsp_chan.interpolated)
);

>>> bench/interp_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts every accepted item and compares results in order.
module interp_checker (
   input  logic  clock,
   input  logic  reset,
   trilin_req_if req_chan,
   trilin_rsp_if rsp_chan,
   output int    mismatch_count,
   output int    pending_count
);
   import trilin_pkg::*;

   localparam longint WEIGHT_ONE = longint'(1) << FRAC_BITS;

   // interpolated values still owed by the block, oldest first
   sample_type interp_due [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] interp_checker: %s", $realtime, what);
      mismatch_count++;
   endtask

   // one linear step; >>> on a signed longint floors toward minus infinity
   function automatic longint lerp_axis(input longint lo, input longint hi,
                                        input weight_type w);
      longint wt;
      wt = longint'(w);
      return (lo * (WEIGHT_ONE - wt) + hi * wt) >>> FRAC_BITS;
   endfunction

   // four lerps along x, two along y, one along z, truncating at each step
   function automatic sample_type interp_cell(input sample_type c [8],
                                              input weight_type wx,
                                              input weight_type wy,
                                              input weight_type wz);
      longint x00, x10, x01, x11, y0, y1;
      x00 = lerp_axis(c[0], c[1], wx);
      x10 = lerp_axis(c[2], c[3], wx);
      x01 = lerp_axis(c[4], c[5], wx);
      x11 = lerp_axis(c[6], c[7], wx);
      y0  = lerp_axis(x00, x10, wy);
      y1  = lerp_axis(x01, x11, wy);
      return sample_type'(lerp_axis(y0, y1, wz));
   endfunction

   always @(posedge clock) begin
      sample_type corners [8];
      sample_type seen;
      sample_type due;
      if (!reset) begin
         // new item: compute its result now
         if (req_chan.valid && req_chan.ready) begin
            corners[0] = req_chan.corner_x0y0z0;
            corners[1] = req_chan.corner_x1y0z0;
            corners[2] = req_chan.corner_x0y1z0;
            corners[3] = req_chan.corner_x1y1z0;
            corners[4] = req_chan.corner_x0y0z1;
            corners[5] = req_chan.corner_x1y0z1;
            corners[6] = req_chan.corner_x0y1z1;
            corners[7] = req_chan.corner_x1y1z1;
            interp_due.push_back(interp_cell(corners, req_chan.weight_x,
                                             req_chan.weight_y, req_chan.weight_z));
         end
         // result leaving the block: match against the oldest item
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen = rsp_chan.interpolated;
            if (interp_due.size() == 0) begin
               report_mismatch($sformatf("result %0d with no item outstanding", seen));
            end else begin
               due = interp_due.pop_front();
               if (seen !== due)
                  report_mismatch($sformatf("interpolated got %0d expected %0d", seen, due));
            end
         end
         pending_count <= interp_due.size();
      end
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import trilin_pkg::*;

   localparam int IDLE_PERCENT = 18;
   localparam int RANDOM_ITEMS = 400;
   localparam int DIR_PATTERNS = 5;
   localparam int DIR_WEIGHTS  = 5;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int TAIL_CYCLES  = 12;

   logic clock;
   logic reset;
   bit   steady;
   int   mismatch_count;
   int   pending_count;

   trilin_req_if req_chan ();
   trilin_rsp_if rsp_chan ();

   trilinear_interp_fixed16 u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   interp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #1ms;
      $display("** trilinear_interp_fixed16: FAILED **");
      $finish;
   end

   // result side back-pressure, off during the steady stretch
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // present one cell and hold it until accepted
   task automatic send_cell(input sample_type c [8], input weight_type wx,
                            input weight_type wy, input weight_type wz);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.corner_x0y0z0 <= c[0];
      req_chan.corner_x1y0z0 <= c[1];
      req_chan.corner_x0y1z0 <= c[2];
      req_chan.corner_x1y1z0 <= c[3];
      req_chan.corner_x0y0z1 <= c[4];
      req_chan.corner_x1y0z1 <= c[5];
      req_chan.corner_x0y1z1 <= c[6];
      req_chan.corner_x1y1z1 <= c[7];
      req_chan.weight_x      <= wx;
      req_chan.weight_y      <= wy;
      req_chan.weight_z      <= wz;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // mostly full-range, with extremes and values near zero for rounding
   function automatic sample_type pick_corner();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? sample_type'(16'h7FFF) : sample_type'(16'h8000);
         1: return sample_type'(int'($urandom_range(0, 6)) - 3);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic weight_type pick_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return weight_type'($urandom_range(0, 3));
         default: return weight_type'($urandom);
      endcase
   endfunction

   initial begin
      sample_type c [8];
      weight_type dir_wx [DIR_WEIGHTS];
      weight_type dir_wy [DIR_WEIGHTS];
      weight_type dir_wz [DIR_WEIGHTS];
      int guard;

      // zero, maximum, half, one axis at maximum, mixed small, half and maximum
      dir_wx = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001};
      dir_wy = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h8000};
      dir_wz = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF};

      steady = 1'b0;
      reset  = 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.corner_x0y0z0 <= '0;
      req_chan.corner_x1y0z0 <= '0;
      req_chan.corner_x0y1z0 <= '0;
      req_chan.corner_x1y1z0 <= '0;
      req_chan.corner_x0y0z1 <= '0;
      req_chan.corner_x1y0z1 <= '0;
      req_chan.corner_x0y1z1 <= '0;
      req_chan.corner_x1y1z1 <= '0;
      req_chan.weight_x      <= '0;
      req_chan.weight_y      <= '0;
      req_chan.weight_z      <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corner patterns crossed with the weight corners
      for (int p = 0; p < DIR_PATTERNS; p++) begin
         for (int i = 0; i < 8; i++) begin
            case (p)
               0: c[i] = sample_type'(i * 4099 - 16000);        // distinct values
               1: c[i] = i[0] ? sample_type'(16'h7FFF) : sample_type'(16'h8000);
               2: c[i] = sample_type'(16'h8000);                // all minimum
               3: c[i] = sample_type'(16'h7FFF);                // all maximum
               default: c[i] = (i == 0) ? sample_type'(-1) : sample_type'(0);  // -0.5 floors
            endcase
         end
         for (int w = 0; w < DIR_WEIGHTS; w++)
            send_cell(c, dir_wx[w], dir_wy[w], dir_wz[w]);
      end

      // random cells; a stretch in the middle runs with no idling on either side
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 270);
         for (int i = 0; i < 8; i++)
            c[i] = pick_corner();
         send_cell(c, pick_weight(), pick_weight(), pick_weight());
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // drain everything still in flight
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending_count != 0 && guard < DRAIN_LIMIT);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("** trilinear_interp_fixed16: PASSED **");
      else
         $display("** trilinear_interp_fixed16: FAILED **");
      $finish;
   end

endmodule
